// ===== hdl/i2c_master_register_access_macros.svh =====
// ----------------------------------------------------------------------------
// i2c master register access assertion macros
// concurrent assertion helpers, empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef I2C_MASTER_REGISTER_ACCESS_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_MACROS_SVH

`ifndef SYNTHESIS
// checked only while out of reset
`define I2CM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define I2CM_ASSERT(lbl, prop, msg)
`define I2CM_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ===== hdl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types and constants of the i2c master register access block
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  typedef enum logic [1:0] {
    OP_TICK       = 2'd0,
    OP_WORD_READ  = 2'd1,
    OP_BURST_READ = 2'd2,
    OP_BYTE_WRITE = 2'd3
  } op_e;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd210;
  localparam logic [7:0] WORD_READ_LEN     = 8'd2;

  // one tick request
  typedef struct packed {
    op_e        opcode;
    logic [6:0] device_address;
    logic [7:0] register_address;
    logic [7:0] write_value;
    logic [7:0] read_length;
    logic       sda_sample;
  } item_t;

  // one tick result
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic       last_byte;
    logic       done_res;
    logic       ack_error;
    logic       busy_res;
  } res_t;

  // classified request between front and back
  typedef struct packed {
    logic       start;
    op_e        kind;
    logic [6:0] device;
    logic [7:0] register;
    logic [7:0] value;
    logic [7:0] length;
    logic       sda;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/i2cm_fifo.sv =====
// ----------------------------------------------------------------------------
// i2cm_fifo
// small first-word-fall-through queue with simultaneous push and pop
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_fifo #(
  parameter type T     = logic,
  parameter int  DEPTH = 2
) (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  push_i,
  input  T     data_i,
  output logic full_o,
  input  wire  pop_i,
  output T     data_o,
  output logic empty_o,
  output logic not_empty_o
);

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  T                mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            push_ok, pop_ok;

  assign full_o      = (count_q == CntW'(DEPTH));
  assign empty_o     = (count_q == '0);
  assign not_empty_o = !empty_o;
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = pop_i && !empty_o;
  assign data_o      = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    ptr_next = (p == PtrW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_ok) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_ok && !pop_ok) begin
        count_q <= count_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// i2cm_front
// classifies a tick request into a command for the bus engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front
  import i2cm_pkg::*;
(
  input  item_t item_i,
  output cmd_t  cmd_o
);

  always_comb begin
    cmd_o.start    = (item_i.opcode != OP_TICK);
    cmd_o.kind     = item_i.opcode;
    cmd_o.device   = item_i.device_address;
    cmd_o.register = item_i.register_address;
    cmd_o.value    = item_i.write_value;
    cmd_o.sda      = item_i.sda_sample;
    case (item_i.opcode)
      OP_WORD_READ:  cmd_o.length = WORD_READ_LEN;
      // zero burst length counts as one byte
      OP_BURST_READ: cmd_o.length = (item_i.read_length == '0) ? 8'd1 : item_i.read_length;
      default:       cmd_o.length = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// i2cm_engine
// bus sequencer, one half-bit interval per command
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2cm_engine
  import i2cm_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire [7:0]  ack_timeout_i,
  input  wire        cmd_valid_i,
  input  cmd_t       cmd_i,
  output logic       cmd_pop_o,
  input  wire        res_full_i,
  output logic       res_push_o,
  output res_t       res_o
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_TX_DEVW, PH_ACK_DEVW, PH_TX_REG, PH_ACK_REG,
    PH_TX_DATA, PH_ACK_DATA, PH_RESTART, PH_TX_DEVR, PH_ACK_DEVR,
    PH_RX, PH_MACK, PH_STOP, PH_STOP_ERR
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [1:0] half_q, half_d;
  logic [3:0] bit_q, bit_d;
  logic [7:0] shift_q, shift_d;
  logic [7:0] left_q, left_d;
  op_e        kind_q, kind_d;
  logic [6:0] dev_q, dev_d;
  logic [7:0] reg_q, reg_d;
  logic [7:0] val_q, val_d;
  logic [7:0] wait_q, wait_d;
  logic [7:0] wait_inc;
  logic [7:0] rx_byte;
  logic       step;

  assign step       = cmd_valid_i && !res_full_i;
  assign cmd_pop_o  = step;
  assign res_push_o = step;
  assign wait_inc   = wait_q + 8'd1;
  assign rx_byte    = {shift_q[6:0], cmd_i.sda};

  always_comb begin
    phase_d = phase_q;
    half_d  = half_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    left_d  = left_q;
    kind_d  = kind_q;
    dev_d   = dev_q;
    reg_d   = reg_q;
    val_d   = val_q;
    wait_d  = wait_q;

    res_o             = '0;
    res_o.scl_level   = 1'b1;
    res_o.sda_release = 1'b1;
    res_o.busy_res    = 1'b1;

    case (phase_q)
      PH_START: begin
        res_o.scl_level   = (half_q == 2'd0);
        res_o.sda_release = 1'b0;
        if (half_q == 2'd0) begin
          half_d = 2'd1;
        end else begin
          phase_d = PH_TX_DEVW;
          shift_d = {dev_q, 1'b0};
          bit_d   = '0;
          half_d  = '0;
        end
      end
      PH_TX_DEVW, PH_TX_REG, PH_TX_DATA, PH_TX_DEVR: begin
        res_o.sda_release = shift_q[7];
        res_o.scl_level   = (half_q != 2'd0);
        if (half_q == 2'd0) begin
          half_d = 2'd1;
        end else begin
          half_d  = '0;
          shift_d = {shift_q[6:0], 1'b0};
          bit_d   = bit_q + 4'd1;
          if (bit_q >= 4'd7) begin
            bit_d  = '0;
            wait_d = '0;
            case (phase_q)
              PH_TX_DEVW: phase_d = PH_ACK_DEVW;
              PH_TX_REG:  phase_d = PH_ACK_REG;
              PH_TX_DATA: phase_d = PH_ACK_DATA;
              default:    phase_d = PH_ACK_DEVR;
            endcase
          end
        end
      end
      PH_ACK_DEVW, PH_ACK_REG, PH_ACK_DATA, PH_ACK_DEVR: begin
        if (half_q == 2'd0) begin
          res_o.scl_level = 1'b0;
          half_d          = 2'd1;
        end else if (!cmd_i.sda) begin
          half_d = '0;
          bit_d  = '0;
          case (phase_q)
            PH_ACK_DEVW: begin
              phase_d = PH_TX_REG;
              shift_d = reg_q;
            end
            PH_ACK_REG: begin
              if (kind_q == OP_BYTE_WRITE) begin
                phase_d = PH_TX_DATA;
                shift_d = val_q;
              end else begin
                phase_d = PH_RESTART;
              end
            end
            PH_ACK_DATA: phase_d = PH_STOP;
            default: begin
              phase_d = PH_RX;
              shift_d = '0;
            end
          endcase
        end else begin
          wait_d = wait_inc;
          if (wait_inc >= ack_timeout_i) begin
            phase_d = PH_STOP_ERR;
            half_d  = '0;
          end
        end
      end
      PH_RESTART: begin
        res_o.scl_level   = (half_q == 2'd1) || (half_q == 2'd2);
        res_o.sda_release = (half_q < 2'd2);
        if (half_q < 2'd3) begin
          half_d = half_q + 2'd1;
        end else begin
          phase_d = PH_TX_DEVR;
          shift_d = {dev_q, 1'b1};
          bit_d   = '0;
          half_d  = '0;
        end
      end
      PH_RX: begin
        if (half_q == 2'd0) begin
          res_o.scl_level = 1'b0;
          half_d          = 2'd1;
        end else begin
          half_d  = '0;
          shift_d = rx_byte;
          bit_d   = bit_q + 4'd1;
          if (bit_q >= 4'd7) begin
            res_o.byte_valid = 1'b1;
            res_o.read_byte  = rx_byte;
            res_o.last_byte  = (left_q <= 8'd1);
            bit_d            = '0;
            phase_d          = PH_MACK;
          end
        end
      end
      PH_MACK: begin
        res_o.sda_release = !(left_q > 8'd1);
        res_o.scl_level   = (half_q != 2'd0);
        if (half_q == 2'd0) begin
          half_d = 2'd1;
        end else begin
          half_d = '0;
          if (left_q > 8'd1) begin
            left_d  = left_q - 8'd1;
            shift_d = '0;
            phase_d = PH_RX;
          end else begin
            phase_d = PH_STOP;
          end
        end
      end
      PH_STOP, PH_STOP_ERR: begin
        if (half_q == 2'd0) begin
          res_o.scl_level   = 1'b0;
          res_o.sda_release = 1'b0;
          half_d            = 2'd1;
        end else if (half_q == 2'd1) begin
          res_o.sda_release = 1'b0;
          half_d            = 2'd2;
        end else begin
          res_o.done_res  = 1'b1;
          res_o.ack_error = (phase_q == PH_STOP_ERR);
          res_o.busy_res  = 1'b0;
          phase_d         = PH_IDLE;
          half_d          = '0;
        end
      end
      default: begin
        phase_d        = PH_IDLE;
        half_d         = '0;
        res_o.busy_res = 1'b0;
        if (cmd_i.start) begin
          res_o.busy_res = 1'b1;
          kind_d         = cmd_i.kind;
          dev_d          = cmd_i.device;
          reg_d          = cmd_i.register;
          val_d          = cmd_i.value;
          left_d         = cmd_i.length;
          bit_d          = '0;
          wait_d         = '0;
          shift_d        = '0;
          phase_d        = PH_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      half_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      kind_q  <= OP_TICK;
      dev_q   <= '0;
      reg_q   <= '0;
      val_q   <= '0;
      wait_q  <= '0;
    end else if (step) begin
      phase_q <= phase_d;
      half_q  <= half_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      kind_q  <= kind_d;
      dev_q   <= dev_d;
      reg_q   <= reg_d;
      val_q   <= val_d;
      wait_q  <= wait_d;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/i2c_master_register_access.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access
// i2c master for word read, burst read and byte write register transactions
// ----------------------------------------------------------------------------
// path: an accepted tick request is written into the command queue, and the
//   sequencer's step on it writes its result into the result queue
// throughput: one request per cycle while the result queue has room, set by
//   the step of the bus sequencer in the back end
// reset: sequencer idle, both queues empty, ack_timeout back to 210
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "i2c_master_register_access_macros.svh"

module i2c_master_register_access
  import i2cm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  // request side
  input  wire        push,
  input  item_t      item_i,
  output logic       full,
  // result side
  output logic       empty,
  output res_t       res_o,
  input  wire        pop,
  // configuration write channel (ack_timeout)
  input  wire        cfg_valid_i,
  input  wire [7:0]  cfg_data_i,
  output logic       cfg_ready_o
);

  // configuration register, always writable
  logic [7:0] ack_timeout_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_timeout_q <= ACK_TIMEOUT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      ack_timeout_q <= cfg_data_i;
    end
  end

  // front end: classify the tick request
  cmd_t front_cmd;

  i2cm_front u_front (
    .item_i (item_i),
    .cmd_o  (front_cmd)
  );

  // command queue between front and back, decouples request stalls
  cmd_t cmd_head;
  logic cmd_pop, cmd_empty, cmd_valid;

  i2cm_fifo #(
    .T     (cmd_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_i      (front_cmd),
    .full_o      (full),
    .pop_i       (cmd_pop),
    .data_o      (cmd_head),
    .empty_o     (cmd_empty),
    .not_empty_o (cmd_valid)
  );

  // back end: bus sequencer, steps once per command when result room exists
  res_t eng_res;
  logic res_push, res_full, res_valid;

  i2cm_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ack_timeout_i (ack_timeout_q),
    .cmd_valid_i   (cmd_valid),
    .cmd_i         (cmd_head),
    .cmd_pop_o     (cmd_pop),
    .res_full_i    (res_full),
    .res_push_o    (res_push),
    .res_o         (eng_res)
  );

  // result queue, lets the sequencer run while the consumer stalls
  i2cm_fifo #(
    .T     (res_t),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_push),
    .data_i      (eng_res),
    .full_o      (res_full),
    .pop_i       (pop),
    .data_o      (res_o),
    .empty_o     (empty),
    .not_empty_o (res_valid)
  );

  // an accepted request is waiting in the command queue in the next cycle
  `I2CM_ASSERT(a_cmd_held, (push && !full) |=> !cmd_empty, "accepted request lost")
  // a sequencer step always leaves a result to deliver
  `I2CM_ASSERT(a_step_res, cmd_pop |=> res_valid, "stepped request gave no result")
  // the sequencer never steps into a full result queue
  `I2CM_ASSERT(a_no_overrun, !(res_full && res_push), "result queue overrun")
  // an error result is always a finishing result
  `I2CM_ASSERT(a_err_done, (res_valid && res_o.ack_error) |-> res_o.done_res,
    "ack error without done")

endmodule

`default_nettype wire
